// ----- hdl/ctm_pkg.sv -----
// Shared types and constants for the centroid track matcher.
// No dependencies; imported by the datapath, controller and top level.
package ctm_pkg;

    localparam int MAX_TRACKS_DEF = 64;
    localparam int COORD_BITS_DEF = 12;
    localparam int THRESH_W       = 13;
    localparam int THRESH_RESET   = 50;
    localparam int LIMIT_W        = 2 * THRESH_W + 2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_done;
    } t_status;

endpackage

// ----- hdl/ctm_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
module ctm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ctm_datapath.sv -----
// Datapath: centroid capture, pipelined distance scan over the track RAM,
// commit of match or insert and the result word. Uses ctm_pkg and ctm_ram.
module ctm_datapath import ctm_pkg::*; #(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IDW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
    localparam int CNTW = $clog2(MAX_TRACKS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_we,
    input  logic [THRESH_W-1:0]   i_cfg_data,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    input  logic                  i_last_of_frame,
    output logic                  o_result_valid,
    output logic [IDW-1:0]        o_track_id,
    output logic                  o_is_new,
    output logic                  o_table_full,
    output logic [CNTW-1:0]       o_tracked_count,
    output logic                  o_frame_had_new
);

    localparam int CW   = COORD_BITS + 2;
    localparam int SQW  = 2 * CW;
    localparam int SUMW = SQW + 1;
    localparam int CMPW = (SUMW > LIMIT_W) ? SUMW : LIMIT_W;

    logic [LIMIT_W-1:0]    r_limit;
    logic [CW-1:0]         r_cx;
    logic [CW-1:0]         r_cy;
    logic                  r_last;
    logic [CNTW-1:0]       r_rd_idx;
    logic                  r_v1;
    logic                  r_v2;
    logic [IDW-1:0]        r_idx1;
    logic [IDW-1:0]        r_idx2;
    logic [SQW-1:0]        r_sqx;
    logic [SQW-1:0]        r_sqy;
    logic [CNTW-1:0]       r_total;
    logic                  r_new_seen;
    logic                  r_res_valid;
    logic [IDW-1:0]        r_id;
    logic                  r_is_new;
    logic                  r_full;
    logic [CNTW-1:0]       r_count;
    logic                  r_frame_new;

    logic [2*THRESH_W-1:0] w_thr_sq;
    logic [CW-1:0]         w_cx;
    logic [CW-1:0]         w_cy;
    logic [2*CW-1:0]       w_rdata;
    logic [CW-1:0]         w_rd_x;
    logic [CW-1:0]         w_rd_y;
    logic [CW-1:0]         w_dx;
    logic [CW-1:0]         w_dy;
    logic [SQW-1:0]        w_sqx;
    logic [SQW-1:0]        w_sqy;
    logic [SUMW-1:0]       w_sum;
    logic                  w_issue;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_ins;
    logic                  w_seen;
    logic                  w_we;
    logic [IDW-1:0]        w_waddr;
    logic [IDW-1:0]        w_id;
    logic [CNTW-1:0]       n_total;

    assign w_thr_sq = (2*THRESH_W)'(i_cfg_data) * (2*THRESH_W)'(i_cfg_data);
    assign w_cx = {1'b0, i_box_x, 1'b0} + CW'(i_box_width);
    assign w_cy = {1'b0, i_box_y, 1'b0} + CW'(i_box_height);

    assign w_rd_x = w_rdata[2*CW-1:CW];
    assign w_rd_y = w_rdata[CW-1:0];
    assign w_dx   = (r_cx >= w_rd_x) ? (r_cx - w_rd_x) : (w_rd_x - r_cx);
    assign w_dy   = (r_cy >= w_rd_y) ? (r_cy - w_rd_y) : (w_rd_y - r_cy);
    assign w_sqx  = SQW'(w_dx) * SQW'(w_dx);
    assign w_sqy  = SQW'(w_dy) * SQW'(w_dy);
    assign w_sum  = SUMW'(r_sqx) + SUMW'(r_sqy);

    assign w_issue = i_cmd.scan && (r_rd_idx < r_total);
    assign w_hit   = r_v2 && (CMPW'(w_sum) < CMPW'(r_limit));
    assign w_full  = !w_hit && (r_total == CNTW'(MAX_TRACKS));
    assign w_ins   = !w_hit && !w_full;
    assign w_seen  = r_new_seen | w_ins;
    assign w_we    = i_cmd.commit && !w_full;
    assign w_waddr = w_hit ? r_idx2 : r_total[IDW-1:0];
    assign w_id    = w_hit ? r_idx2 : (w_full ? '0 : r_total[IDW-1:0]);
    assign n_total = w_ins ? (r_total + CNTW'(1)) : r_total;

    assign o_status.hit       = w_hit;
    assign o_status.scan_done = (r_rd_idx >= r_total) && !r_v1 && !r_v2;

    ctm_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_TRACKS)
    ) u_track_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_cx, r_cy}),
        .i_raddr (r_rd_idx[IDW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_W'(4 * THRESH_RESET * THRESH_RESET);
            r_rd_idx    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_total     <= '0;
            r_new_seen  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= {w_thr_sq, 2'b00};
            end
            r_res_valid <= i_cmd.commit;
            if (i_cmd.start) begin
                r_rd_idx <= '0;
                r_v1     <= 1'b0;
                r_v2     <= 1'b0;
            end else if (i_cmd.commit) begin
                r_v1       <= 1'b0;
                r_v2       <= 1'b0;
                r_total    <= n_total;
                r_new_seen <= r_last ? 1'b0 : w_seen;
            end else begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
                if (w_issue) begin
                    r_rd_idx <= r_rd_idx + CNTW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cx   <= w_cx;
            r_cy   <= w_cy;
            r_last <= i_last_of_frame;
        end
        r_idx1 <= r_rd_idx[IDW-1:0];
        r_idx2 <= r_idx1;
        r_sqx  <= w_sqx;
        r_sqy  <= w_sqy;
        if (i_cmd.commit) begin
            r_id        <= w_id;
            r_is_new    <= w_ins;
            r_full      <= w_full;
            r_count     <= n_total;
            r_frame_new <= r_last & w_seen;
        end
    end

    assign o_result_valid  = r_res_valid;
    assign o_track_id      = r_id;
    assign o_is_new        = r_is_new;
    assign o_table_full    = r_full;
    assign o_tracked_count = r_count;
    assign o_frame_had_new = r_frame_new;

endmodule

// ----- hdl/ctm_ctrl.sv -----
// Controller: sequences accept, scan and commit for one box at a time.
// Uses ctm_pkg.
module ctm_ctrl import ctm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.start = i_start;
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_busy     = 1'b1;
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.scan_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/centroid_track_matcher_core.sv -----
// Centroid track matcher, top level: controller plus datapath.
// Depends on ctm_pkg, ctm_ctrl, ctm_datapath (which holds ctm_ram).
//
// Usage:
//   A box word is taken at a clock edge where start is high and busy is low.
//   The threshold register is written through i_cfg_valid / o_cfg_ready /
//   i_cfg_data (always ready); write it only while the block is idle.
//   Each box gives one result word, shown for one cycle with o_result_valid;
//   the receiver cannot stall it, and the block can take the next box in that
//   same cycle.
// Scan, with N tracks stored:
//   the scan reads one stored centroid a cycle from the track RAM through a
//   three-stage read/square/compare pipeline. A match at index k ends the
//   scan there, a miss reads all N entries. The result appears in the same
//   cycle as busy falls. A new box is taken only once the previous one has
//   been committed and busy is low.
// Reset:
//   synchronous, clears the track count, the frame flag and the pipeline, and
//   sets the threshold to 50 pixels. Centroid RAM contents are not cleared.
module centroid_track_matcher_core import ctm_pkg::*; #(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IDW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1,
    localparam int CNTW = $clog2(MAX_TRACKS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    input  logic                  i_last_of_frame,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [THRESH_W-1:0]   i_cfg_data,
    output logic                  o_result_valid,
    output logic [IDW-1:0]        o_track_id,
    output logic                  o_is_new,
    output logic                  o_table_full,
    output logic [CNTW-1:0]       o_tracked_count,
    output logic                  o_frame_had_new
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    ctm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    ctm_datapath #(
        .MAX_TRACKS (MAX_TRACKS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_box_x         (i_box_x),
        .i_box_y         (i_box_y),
        .i_box_width     (i_box_width),
        .i_box_height    (i_box_height),
        .i_last_of_frame (i_last_of_frame),
        .o_result_valid  (o_result_valid),
        .o_track_id      (o_track_id),
        .o_is_new        (o_is_new),
        .o_table_full    (o_table_full),
        .o_tracked_count (o_tracked_count),
        .o_frame_had_new (o_frame_had_new)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted box did not raise busy");

    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $fell(busy))
        else $error("result word outside end of scan");

    a_new_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_is_new) |->
            (CNTW'(o_track_id) + CNTW'(1) == o_tracked_count))
        else $error("new track id does not match track count");

    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_is_new && o_table_full))
        else $error("new track reported with full table");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for centroid_track_matcher_core: directed and random detection boxes,
// results checked against a cycle-free predictor of the track table.
// Depends on ctm_pkg and the centroid_track_matcher_core RTL.
module tb import ctm_pkg::*; ();

    localparam int STALL_LIMIT = 4000;
    localparam int N_PHASES    = 10;
    localparam int MAX_CENTRE  = 3 * 4095;

    typedef struct packed {
        bit [11:0] x;
        bit [11:0] y;
        bit [11:0] w;
        bit [11:0] h;
        bit        last;
    } t_box;

    typedef struct packed {
        int unsigned idx;
        bit [5:0]    track_id;
        bit          is_new;
        bit          table_full;
        bit [6:0]    tracked_count;
        bit          frame_had_new;
    } t_track_result;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [11:0]         i_box_x = '0;
    logic [11:0]         i_box_y = '0;
    logic [11:0]         i_box_width = '0;
    logic [11:0]         i_box_height = '0;
    logic                i_last_of_frame = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [THRESH_W-1:0] i_cfg_data = '0;
    logic                o_result_valid;
    logic [5:0]          o_track_id;
    logic                o_is_new;
    logic                o_table_full;
    logic [6:0]          o_tracked_count;
    logic                o_frame_had_new;

    centroid_track_matcher_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_box_x        (i_box_x),
        .i_box_y        (i_box_y),
        .i_box_width    (i_box_width),
        .i_box_height   (i_box_height),
        .i_last_of_frame(i_last_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_track_id     (o_track_id),
        .o_is_new       (o_is_new),
        .o_table_full   (o_table_full),
        .o_tracked_count(o_tracked_count),
        .o_frame_had_new(o_frame_had_new)
    );

    // predicted track table
    bit [13:0]         trk_cx [MAX_TRACKS_DEF];
    bit [13:0]         trk_cy [MAX_TRACKS_DEF];
    bit [6:0]          track_total = '0;
    bit                new_in_frame = 1'b0;
    bit [THRESH_W-1:0] threshold = THRESH_W'(THRESH_RESET);

    t_box          pending_boxes[$];
    t_track_result expected_tracks[$];

    int  n_errors = 0;
    int  n_boxes = 0;
    int  n_new = 0;
    int  n_matched = 0;
    int  n_dropped = 0;
    int  n_frames = 0;
    int  n_frames_new = 0;
    int  n_settings = 0;
    int  gap_left = 0;
    int  idle_cycles = 0;
    bit  quiet_tail = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_track_result match_or_insert(input t_box b);
        t_track_result r;
        bit [13:0]     cx;
        bit [13:0]     cy;
        longint        limit;
        longint        dx;
        longint        dy;
        bit            hit;
        int            i;
        cx    = {1'b0, b.x, 1'b0} + 14'(b.w);
        cy    = {1'b0, b.y, 1'b0} + 14'(b.h);
        limit = 4 * longint'(threshold) * longint'(threshold);
        r     = '0;
        hit   = 1'b0;
        r.idx = unsigned'(n_boxes);
        for (i = 0; i < track_total && !hit; i++) begin
            dx = longint'(cx) - longint'(trk_cx[i]);
            dy = longint'(cy) - longint'(trk_cy[i]);
            if (dx * dx + dy * dy < limit) begin
                trk_cx[i]  = cx;
                trk_cy[i]  = cy;
                r.track_id = 6'(i);
                hit        = 1'b1;
                n_matched++;
            end
        end
        if (!hit) begin
            if (track_total < MAX_TRACKS_DEF) begin
                r.track_id               = track_total[5:0];
                trk_cx[track_total[5:0]] = cx;
                trk_cy[track_total[5:0]] = cy;
                track_total++;
                r.is_new                 = 1'b1;
                new_in_frame             = 1'b1;
                n_new++;
            end else begin
                r.table_full = 1'b1;
                n_dropped++;
            end
        end
        if (b.last) begin
            r.frame_had_new = new_in_frame;
            new_in_frame    = 1'b0;
            n_frames++;
            if (r.frame_had_new)
                n_frames_new++;
        end
        r.tracked_count = track_total;
        n_boxes++;
        return r;
    endfunction

    // position and size giving a wanted half-pixel centre
    function automatic void split_centroid(input int c, output bit [11:0] pos,
                                           output bit [11:0] size);
        int lo;
        int hi;
        int w;
        lo = (c > 8190) ? c - 8190 : 0;
        hi = (c < 4095) ? c : 4095;
        w  = int'($urandom_range(hi, lo));
        if ((c - w) % 2 != 0)
            w = (w < hi) ? w + 1 : w - 1;
        size = 12'(w);
        pos  = 12'((c - w) / 2);
    endfunction

    function automatic bit [11:0] extreme_coord();
        case ($urandom_range(0, 2))
            0:       return 12'h000;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic int clamp_centre(input int c);
        if (c < 0)
            return 0;
        if (c > MAX_CENTRE)
            return MAX_CENTRE;
        return c;
    endfunction

    // mostly boxes close to a stored track, straddling the match radius
    function automatic t_box random_box();
        t_box b;
        int   pick;
        int   k;
        int   span;
        int   cx;
        int   cy;
        pick = int'($urandom_range(0, 99));
        if (track_total != 0 && pick < 75) begin
            k    = int'($urandom_range(0, track_total - 1));
            span = 3 * int'(threshold) + 2;
            cx   = clamp_centre(int'(trk_cx[k]) + int'($urandom_range(0, 2 * span)) - span);
            cy   = clamp_centre(int'(trk_cy[k]) + int'($urandom_range(0, 2 * span)) - span);
            split_centroid(cx, b.x, b.w);
            split_centroid(cy, b.y, b.h);
        end else if (pick < 90) begin
            b.x = 12'($urandom_range(0, 4095));
            b.y = 12'($urandom_range(0, 4095));
            b.w = 12'($urandom_range(0, 4095));
            b.h = 12'($urandom_range(0, 4095));
        end else begin
            b.x = extreme_coord();
            b.y = extreme_coord();
            b.w = extreme_coord();
            b.h = extreme_coord();
        end
        b.last = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    task automatic queue_box(input t_box b);
        pending_boxes.insert(pending_boxes.size(), b);
    endtask

    task automatic push_box(input bit [11:0] x, input bit [11:0] y, input bit [11:0] w,
                            input bit [11:0] h, input bit last);
        queue_box('{x: x, y: y, w: w, h: h, last: last});
    endtask

    // checked between edges so that the driver's updates have settled
    task automatic wait_idle();
        while (pending_boxes.size() != 0 || start || expected_tracks.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_threshold(input bit [THRESH_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        threshold = value;
        n_settings++;
    endtask

    // box driver
    always @(posedge i_clk) begin
        bit            drive;
        t_box          nb;
        t_track_result res;
        drive = start;
        if (i_rst_n) begin
            if (start && !busy) begin
                res = match_or_insert('{x: i_box_x, y: i_box_y,
                    w: i_box_width, h: i_box_height, last: i_last_of_frame});
                expected_tracks.insert(expected_tracks.size(), res);
                drive = 1'b0;
                if (!quiet_tail && $urandom_range(0, 3) == 0)
                    gap_left = int'($urandom_range(1, 13));
            end
            if (!drive) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_boxes.size() != 0) begin
                    nb = pending_boxes.pop_front();
                    i_box_x         <= nb.x;
                    i_box_y         <= nb.y;
                    i_box_width     <= nb.w;
                    i_box_height    <= nb.h;
                    i_last_of_frame <= nb.last;
                    drive = 1'b1;
                end
            end
        end
        start <= drive;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_track_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_tracks.size() == 0) begin
                report_mismatch("result word with no box outstanding");
            end else begin
                want = expected_tracks.pop_front();
                if (o_track_id !== want.track_id)
                    report_mismatch($sformatf("box %0d track_id %0d, want %0d",
                                              want.idx, o_track_id, want.track_id));
                if (o_is_new !== want.is_new)
                    report_mismatch($sformatf("box %0d is_new %0b, want %0b",
                                              want.idx, o_is_new, want.is_new));
                if (o_table_full !== want.table_full)
                    report_mismatch($sformatf("box %0d table_full %0b, want %0b",
                                              want.idx, o_table_full, want.table_full));
                if (o_tracked_count !== want.tracked_count)
                    report_mismatch($sformatf("box %0d tracked_count %0d, want %0d",
                                              want.idx, o_tracked_count,
                                              want.tracked_count));
                if (o_frame_had_new !== want.frame_had_new)
                    report_mismatch($sformatf("box %0d frame_had_new %0b, want %0b",
                                              want.idx, o_frame_had_new,
                                              want.frame_had_new));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bit [THRESH_W-1:0] thr_plan [N_PHASES];
        int                p;
        thr_plan = '{13'd50, 13'd8191, 13'd3, 13'd120, 13'd1, 13'd0, 13'd700,
                     13'd0, 13'd0, 13'd37};
        thr_plan[7] = THRESH_W'($urandom_range(0, 8191));
        thr_plan[8] = THRESH_W'($urandom_range(0, 400));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset threshold of 50 px: boundary, corners, bit patterns, frame ends
        push_box(12'd0,    12'd0,    12'd0,    12'd0,    1'b0);
        push_box(12'd50,   12'd0,    12'd0,    12'd0,    1'b0);
        push_box(12'd0,    12'd0,    12'd0,    12'd99,   1'b1);
        push_box(12'hFFF,  12'hFFF,  12'hFFF,  12'hFFF,  1'b0);
        push_box(12'hFFF,  12'hFFF,  12'hFFF,  12'hFFE,  1'b1);
        push_box(12'hAAA,  12'h555,  12'h555,  12'hAAA,  1'b0);
        push_box(12'h555,  12'hAAA,  12'hAAA,  12'h555,  1'b0);
        push_box(12'd0,    12'hFFF,  12'd0,    12'hFFF,  1'b0);
        push_box(12'hFFF,  12'd0,    12'hFFF,  12'd0,    1'b1);
        push_box(12'd49,   12'd0,    12'd0,    12'd0,    1'b0);
        push_box(12'd0,    12'd0,    12'hFFF,  12'hFFF,  1'b1);
        wait_idle();

        for (p = 0; p < N_PHASES; p++) begin
            repeat (4) @(posedge i_clk);
            write_threshold(thr_plan[p]);
            quiet_tail = (p == N_PHASES - 1);
            repeat (8) begin
                repeat (25)
                    queue_box(random_box());
                wait_idle();
            end
        end

        repeat (80) @(posedge i_clk);
        if (expected_tracks.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_tracks.size()));

        $display("Ran %0d boxes under %0d threshold settings:", n_boxes, n_settings);
        $display("  %0d new tracks, %0d matches, %0d dropped on a full table.",
                 n_new, n_matched, n_dropped);
        $display("Closed %0d frames, %0d of them with a new track; %0d mismatches.",
                 n_frames, n_frames_new, n_errors);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
